FILE: design/decimal_amount_parser_core_assert.svh
// Assertion macros shared by the parser checker.
`ifndef DECIMAL_AMOUNT_PARSER_CORE_ASSERT_SVH
`define DECIMAL_AMOUNT_PARSER_CORE_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DAP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dap: check failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define DAP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dap: check failed");

`endif

FILE: design/dap_pkg.sv
// ----------------------------------------------------------------------------
// dap_pkg
// Types, constants and tables shared by the decimal amount parser modules.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int FRAC_DIGITS = 8;
    localparam int WHOLE_W     = 64;
    localparam int FRAC_W      = 27;   // holds 10^8 - 1
    localparam int COUNT_W     = 4;
    localparam int SCALE_W     = 27;   // holds 10^8
    localparam int HALF_W      = WHOLE_W / 2;
    localparam int PROD_W      = HALF_W + SCALE_W;
    localparam int FPROD_W     = FRAC_W + SCALE_W;
    localparam int LOSUM_W     = PROD_W + 1;
    localparam int TOTAL_W     = PROD_W + HALF_W + 1;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    localparam logic [SCALE_W-1:0] POW10 [0:FRAC_DIGITS] = '{
        27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
        27'd1000000, 27'd10000000, 27'd100000000
    };

    typedef enum logic [1:0] {
        CH_DIGIT,
        CH_PLUS,
        CH_POINT,
        CH_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

endpackage

FILE: design/dap_queue.sv
// ----------------------------------------------------------------------------
// dap_queue
// Small register queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
module dap_queue
    import dap_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  char_item_t wr_item,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output char_item_t rd_item
);

    char_item_t         mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_en);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(rd_en);
        count_next  = count_reg + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: design/dap_front.sv
// ----------------------------------------------------------------------------
// dap_front
// Accepts characters and sorts them into digit, plus, point or other.
// ----------------------------------------------------------------------------
module dap_front
    import dap_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // is_last
    input  logic       q_full,
    output logic       q_push,
    output char_item_t q_item
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        // ASCII digits carry their value in the low nibble
        q_item.digit = s_tdata[3:0];
        q_item.last  = s_tlast;
        if (s_tdata inside {[CHAR_ZERO:CHAR_NINE]}) begin
            q_item.kind = CH_DIGIT;
        end else if (s_tdata == CHAR_PLUS) begin
            q_item.kind = CH_PLUS;
        end else if (s_tdata == CHAR_POINT) begin
            q_item.kind = CH_POINT;
        end else begin
            q_item.kind = CH_OTHER;
        end
    end

endmodule

FILE: design/dap_back.sv
// ----------------------------------------------------------------------------
// dap_back
// Accumulates whole and fraction digits, then scales and sums the amount
// through a short stall-together pipeline ending in the output register.
// ----------------------------------------------------------------------------
module dap_back
    import dap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  char_item_t  q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] amount, [65:64] status, rest zero
);

    // accumulator state
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic point_reg, point_next;
    logic first_reg, first_next;
    logic mal_reg, mal_next;
    logic big_reg, big_next;
    logic plus_reg, plus_next;

    // stage A: finished text
    logic               a_valid_reg, a_valid_next;
    logic [WHOLE_W-1:0] a_whole_reg, a_whole_next;
    logic [FRAC_W-1:0]  a_frac_reg, a_frac_next;
    logic [COUNT_W-1:0] a_count_reg, a_count_next;
    logic               a_mal_reg, a_mal_next;
    logic               a_big_reg, a_big_next;

    // stage B: partial products
    logic               b_valid_reg;
    logic [PROD_W-1:0]  b_plo_reg, b_phi_reg;
    logic [FPROD_W-1:0] b_fr_reg;
    logic               b_mal_reg, b_big_reg;

    // stage C: low sum
    logic               c_valid_reg;
    logic [LOSUM_W-1:0] c_slo_reg;
    logic [PROD_W-1:0]  c_phi_reg;
    logic               c_mal_reg, c_big_reg;

    // stage D: output register
    logic               m_valid_reg;
    logic [WHOLE_W-1:0] amount_reg, amount_next;
    logic [1:0]         status_reg, status_next;

    logic                 en;
    logic [WHOLE_W+3:0]   whole_x10;
    logic [COUNT_W-1:0]   pad_digits;
    logic [TOTAL_W-1:0]   total;

    function automatic logic [PROD_W:0] b_zero_pad(input logic [PROD_W-1:0] v);
        return {1'b0, v};
    endfunction

    assign en       = !m_valid_reg || m_tready;
    assign q_pop    = q_valid && en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, status_reg, amount_reg};

    assign whole_x10 = ({4'd0, whole_reg} << 3) + ({4'd0, whole_reg} << 1)
                     + (WHOLE_W+4)'(q_item.digit);

    always_comb begin
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        count_next   = count_reg;
        point_next   = point_reg;
        first_next   = first_reg;
        mal_next     = mal_reg;
        big_next     = big_reg;
        plus_next    = plus_reg;
        a_valid_next = 1'b0;
        a_whole_next = a_whole_reg;
        a_frac_next  = a_frac_reg;
        a_count_next = a_count_reg;
        a_mal_next   = a_mal_reg;
        a_big_next   = a_big_reg;
        if (q_pop) begin
            first_next = 1'b0;
            if (!mal_reg) begin
                case (q_item.kind)
                    CH_DIGIT: begin
                        if (point_reg) begin
                            if (count_reg >= COUNT_W'(FRAC_DIGITS)) begin
                                mal_next = 1'b1;
                            end else begin
                                frac_next  = FRAC_W'(frac_reg * FRAC_W'(10))
                                           + FRAC_W'(q_item.digit);
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end else begin
                            plus_next = 1'b0;
                            if (!big_reg) begin
                                if (|whole_x10[WHOLE_W+3:WHOLE_W]) begin
                                    big_next = 1'b1;
                                end else begin
                                    whole_next = whole_x10[WHOLE_W-1:0];
                                end
                            end
                        end
                    end
                    CH_PLUS: begin
                        if (first_reg) begin
                            plus_next = 1'b1;
                        end else begin
                            mal_next = 1'b1;
                        end
                    end
                    CH_POINT: begin
                        if (!point_reg && !plus_reg) begin
                            point_next = 1'b1;
                        end else begin
                            mal_next = 1'b1;
                        end
                    end
                    default: begin
                        mal_next = 1'b1;
                    end
                endcase
            end
            if (q_item.last) begin
                // hand the text to the scaling pipeline and start afresh
                a_valid_next = 1'b1;
                a_whole_next = whole_next;
                a_frac_next  = frac_next;
                a_count_next = count_next;
                a_mal_next   = mal_next || plus_next;
                a_big_next   = big_next;
                whole_next   = '0;
                frac_next    = '0;
                count_next   = '0;
                point_next   = 1'b0;
                first_next   = 1'b1;
                mal_next     = 1'b0;
                big_next     = 1'b0;
                plus_next    = 1'b0;
            end
        end
    end

    assign pad_digits = COUNT_W'(FRAC_DIGITS) - a_count_reg;

    always_comb begin
        total = {b_zero_pad(c_phi_reg), {HALF_W{1'b0}}} + TOTAL_W'(c_slo_reg);
        if (c_mal_reg) begin
            status_next = STATUS_MALFORMED;
        end else if (c_big_reg || (|total[TOTAL_W-1:WHOLE_W])) begin
            status_next = STATUS_OVERFLOW;
        end else begin
            status_next = STATUS_OK;
        end
        amount_next = (status_next == STATUS_OK) ? total[WHOLE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            whole_reg   <= '0;
            frac_reg    <= '0;
            count_reg   <= '0;
            point_reg   <= 1'b0;
            first_reg   <= 1'b1;
            mal_reg     <= 1'b0;
            big_reg     <= 1'b0;
            plus_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            count_reg <= count_next;
            point_reg <= point_next;
            first_reg <= first_next;
            mal_reg   <= mal_next;
            big_reg   <= big_next;
            plus_reg  <= plus_next;
            if (en) begin
                a_valid_reg <= a_valid_next;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_whole_reg <= a_whole_next;
            a_frac_reg  <= a_frac_next;
            a_count_reg <= a_count_next;
            a_mal_reg   <= a_mal_next;
            a_big_reg   <= a_big_next;

            b_plo_reg <= PROD_W'(a_whole_reg[HALF_W-1:0]) * PROD_W'(POW10[FRAC_DIGITS]);
            b_phi_reg <= PROD_W'(a_whole_reg[WHOLE_W-1:HALF_W])
                       * PROD_W'(POW10[FRAC_DIGITS]);
            b_fr_reg  <= FPROD_W'(a_frac_reg) * FPROD_W'(POW10[pad_digits]);
            b_mal_reg <= a_mal_reg;
            b_big_reg <= a_big_reg;

            c_slo_reg <= LOSUM_W'(b_plo_reg) + LOSUM_W'(b_fr_reg);
            c_phi_reg <= b_phi_reg;
            c_mal_reg <= b_mal_reg;
            c_big_reg <= b_big_reg;

            amount_reg <= amount_next;
            status_reg <= status_next;
        end
    end

endmodule

FILE: design/decimal_amount_parser_core.sv
// ----------------------------------------------------------------------------
// decimal_amount_parser_core
// Parses a decimal amount text into an unsigned 64-bit value times 10^8.
// ----------------------------------------------------------------------------
// Input stream s_*: one ASCII character per request in s_tdata[7:0], with
// s_tlast high on the final character of an amount text.
// Result stream m_*: one request per text, issued for the last character:
// m_tdata[63:0] holds the amount scaled by 10^8, m_tdata[65:64] the status
// (0 ok, 1 malformed, 2 overflow); the amount is zero unless status is ok.
// Characters that are not last give no result.
// Throughput: one character per cycle, texts back to back, while not stalled.
// Path: once the last character is taken it leaves the four-entry queue
// into the digit accumulator, then come three scaling stages (two 32x27
// partial products and the scaled fraction, a low add, a final add with
// overflow check in the output register) before m_tvalid rises.
// Reset (aresetn low, synchronous) empties the queue and pipeline and
// clears the parser to the start of a new text.
// When m_tready is low with a result waiting, the result holds and the
// pipeline stalls; the queue keeps taking characters until its four entries
// are full, after which s_tready drops.
// ----------------------------------------------------------------------------
module decimal_amount_parser_core
    import dap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] amount, [65:64] status, rest zero
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    char_item_t push_item;
    char_item_t pop_item;

    dap_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    dap_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_item  (push_item),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (pop_item)
    );

    dap_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: design/dap_checker.sv
// ----------------------------------------------------------------------------
// dap_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
`include "decimal_amount_parser_core_assert.svh"

module dap_checker
    import dap_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic [1:0] m_status;
    logic       status_known;
    logic       amount_zero;
    logic       pad_zero;

    assign m_status     = m_tdata[65:64];
    assign status_known = (m_status == STATUS_OK) || (m_status == STATUS_MALFORMED)
                       || (m_status == STATUS_OVERFLOW);
    assign amount_zero  = (m_tdata[63:0] == 64'd0);
    assign pad_zero     = (m_tdata[71:66] == 6'd0);

    `DAP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `DAP_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `DAP_ASSERT_IMPL(a_status_code, aclk, aresetn, m_tvalid, status_known)
    `DAP_ASSERT_IMPL(a_fault_zero, aclk, aresetn, m_tvalid && !status_ok(m_status), amount_zero)
    `DAP_ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, pad_zero)

    function automatic logic status_ok(input logic [1:0] s);
        return s == STATUS_OK;
    endfunction

endmodule

bind decimal_amount_parser_core dap_checker u_dap_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
